[hdl/periodic_timer_catch_up_unit_macros.svh]
// Assertion macros shared by the timer catch-up RTL
`ifndef PERIODIC_TIMER_CATCH_UP_UNIT_MACROS_SVH
`define PERIODIC_TIMER_CATCH_UP_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PTCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PTCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ptcu_pkg.sv]
// Package: types and constants of the timer catch-up unit
`timescale 1ns / 1ps
package ptcu_pkg;

    localparam int PERIOD_W     = 32;
    localparam int OUT_W        = 32;
    localparam int NOW_W        = 32;
    localparam int KIND_W       = 2;
    localparam int TIME_W_DEF   = 32;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK   = 2'd0,
        KIND_CYCLE   = 2'd1,
        KIND_RESTART = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ELAP,
        S_DIV,
        S_DONE
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[hdl/ptcu_in_if.sv]
// Input channel interface: one timer item
`timescale 1ns / 1ps
interface ptcu_in_if;
    logic                                valid;
    logic                                ready;
    logic [ptcu_pkg::KIND_W-1:0]         kind;
    logic [ptcu_pkg::NOW_W-1:0]          now;
    logic                                regular;

    modport source (output valid, output kind, output now, output regular, input ready);
    modport sink   (input valid, input kind, input now, input regular, output ready);
endinterface

[hdl/ptcu_out_if.sv]
// Output channel interface: one result item
`timescale 1ns / 1ps
interface ptcu_out_if;
    logic                                valid;
    logic                                ready;
    logic                                due;
    logic [ptcu_pkg::OUT_W-1:0]          periods;

    modport source (output valid, output due, output periods, input ready);
    modport sink   (input valid, input due, input periods, output ready);
endinterface

[hdl/ptcu_div.sv]
// Iterative restoring divider: one quotient bit per cycle, one shared subtractor
`timescale 1ns / 1ps
module ptcu_div #(
    parameter int TIME_WIDTH = ptcu_pkg::TIME_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [TIME_WIDTH-1:0]           i_dividend,
    input  logic [ptcu_pkg::PERIOD_W-1:0]   i_divisor,
    output logic [TIME_WIDTH-1:0]           o_quot,
    output logic [ptcu_pkg::PERIOD_W-1:0]   o_rem,
    output ptcu_pkg::t_div_stat             o_stat
);
    import ptcu_pkg::*;

    localparam int CNT_W = $clog2(TIME_WIDTH + 1);

    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [TIME_WIDTH-1:0]  r_quot;
    logic [PERIOD_W-1:0]    r_rem;

    logic [PERIOD_W:0]      shifted;
    logic [PERIOD_W+1:0]    diff;
    logic                   borrow;

    assign shifted = {r_rem, r_quot[TIME_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_divisor};
    assign borrow  = diff[PERIOD_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TIME_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder stays below the divisor, so 32 bits hold it
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= borrow ? shifted[PERIOD_W-1:0] : diff[PERIOD_W-1:0];
            r_quot <= {r_quot[TIME_WIDTH-2:0], ~borrow};
        end
    end

    assign o_quot      = r_quot;
    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

`include "periodic_timer_catch_up_unit_macros.svh"

    `PTCU_ASSERT_NOW(a_no_restart_busy, i_clk, i_rst_n, i_start, !r_busy,
                     "divider restarted while busy")
    `PTCU_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy),
                     "done without a run")
    `PTCU_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_done, r_rem < i_divisor,
                     "remainder not below divisor")

endmodule

[hdl/periodic_timer_catch_up_unit.sv]
// Interval timer with missed-period count: top level and sequencer
//
// Usage: configuration port i_cfg_we / i_cfg_wdata sets the period (a zero
// write stores 1). Input channel i_in carries kind, now and regular; output
// channel o_out returns due and periods, one result item per input item.
// An item is taken when valid and ready are both high.
// Flow: a cycle item runs the radix-2 divider, one quotient bit per cycle.
// A check item computes the elapsed time and skips the divider; restart and
// the unused kind go straight to the result. One item is in flight at a time
// and ready is high only while the sequencer is idle, so the next item can be
// taken in the cycle after the result is registered.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits; if the receiver stalls, the next item finishes
// its work and then holds until the output register frees.
// Reset (synchronous, active low): reference time 0, period 1, no result
// pending, sequencer idle.
`timescale 1ns / 1ps
module periodic_timer_catch_up_unit #(
    parameter int TIME_WIDTH = ptcu_pkg::TIME_W_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ptcu_pkg::PERIOD_W-1:0]   i_cfg_wdata,
    ptcu_in_if.sink                         i_in,
    ptcu_out_if.source                      o_out
);
    import ptcu_pkg::*;

    t_state                 r_state, n_state;
    logic [KIND_W-1:0]      r_kind, n_kind;
    logic [TIME_WIDTH-1:0]  r_now, n_now;
    logic                   r_regular, n_regular;
    logic [TIME_WIDTH-1:0]  r_elapsed, n_elapsed;
    logic [TIME_WIDTH-1:0]  r_ref, n_ref;
    logic [PERIOD_W-1:0]    r_period;
    logic                   r_ovalid, n_ovalid;
    logic                   r_due, n_due;
    logic [OUT_W-1:0]       r_periods, n_periods;

    logic                   div_start;
    logic [TIME_WIDTH-1:0]  div_quot;
    logic [PERIOD_W-1:0]    div_rem;
    t_div_stat              div_stat;

    logic [TIME_WIDTH+NOW_W-1:0]    now_ext;
    logic [TIME_WIDTH+PERIOD_W-1:0] rem_ext;
    logic [TIME_WIDTH+PERIOD_W-1:0] el_ext;
    logic [TIME_WIDTH+PERIOD_W-1:0] per_ext;
    logic [TIME_WIDTH+OUT_W-1:0]    quot_ext;
    logic                           accept;
    logic                           out_free;

    assign now_ext  = {{TIME_WIDTH{1'b0}}, i_in.now};
    assign rem_ext  = {{TIME_WIDTH{1'b0}}, div_rem};
    assign el_ext   = {{PERIOD_W{1'b0}}, r_elapsed};
    assign per_ext  = {{TIME_WIDTH{1'b0}}, r_period};
    assign quot_ext = {{OUT_W{1'b0}}, div_quot};

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    ptcu_div #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_now - r_ref),
        .i_divisor  (r_period),
        .o_quot     (div_quot),
        .o_rem      (div_rem),
        .o_stat     (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ref    <= '0;
            r_period <= PERIOD_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ref    <= n_ref;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_period <= (i_cfg_wdata == '0) ? PERIOD_RESET : i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_now     <= n_now;
        r_regular <= n_regular;
        r_elapsed <= n_elapsed;
        r_due     <= n_due;
        r_periods <= n_periods;
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_now       = r_now;
        n_regular   = r_regular;
        n_elapsed   = r_elapsed;
        n_ref       = r_ref;
        n_due       = r_due;
        n_periods   = r_periods;
        n_ovalid    = r_ovalid && !o_out.ready;
        div_start   = 1'b0;
        i_in.ready  = 1'b0;

        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    n_kind    = i_in.kind;
                    n_now     = now_ext[TIME_WIDTH-1:0];
                    n_regular = i_in.regular;
                    if (i_in.kind inside {KIND_CHECK, KIND_CYCLE}) begin
                        n_state = S_ELAP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ELAP: begin
                n_elapsed = r_now - r_ref;
                if (r_kind == KIND_CYCLE) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ovalid  = 1'b1;
                    n_due     = 1'b0;
                    n_periods = '0;
                    n_state   = S_IDLE;
                    case (r_kind)
                        KIND_CHECK: begin
                            n_due = (el_ext >= per_ext);
                        end
                        KIND_CYCLE: begin
                            n_periods = quot_ext[OUT_W-1:0];
                            if (div_quot != '0) begin
                                n_due = 1'b1;
                                // count * period = elapsed - remainder, so the
                                // regular advance lands on now - remainder
                                n_ref = r_regular ? (r_now - rem_ext[TIME_WIDTH-1:0])
                                                  : r_now;
                            end
                        end
                        KIND_RESTART: begin
                            n_ref = r_now;
                        end
                        default: begin
                            n_ref = r_ref;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.due     = r_due;
    assign o_out.periods = r_periods;

`include "periodic_timer_catch_up_unit_macros.svh"

    `PTCU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_in.ready,
                      "ready high after accept")
    `PTCU_ASSERT_NOW(a_period_nonzero, i_clk, i_rst_n, 1'b1, r_period != '0,
                     "period is zero")
    `PTCU_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n, div_stat.done,
                     r_state == S_DIV, "divider done outside wait")
    `PTCU_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, r_state == S_DONE && out_free,
                      r_ovalid && r_state == S_IDLE, "finished item not emitted")

endmodule

[sim/timer_result_checker.sv]
`timescale 1ns / 1ps
// Checker: predicts due flag and period count of the timer unit and compares each result
module timer_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptcu_pkg::PERIOD_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [ptcu_pkg::KIND_W-1:0]   i_in_kind,
    input  logic [ptcu_pkg::NOW_W-1:0]    i_in_now,
    input  logic                          i_in_regular,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_out_due,
    input  logic [ptcu_pkg::OUT_W-1:0]    i_out_periods,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import ptcu_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic             due;
        logic [OUT_W-1:0] periods;
    } t_timer_result;

    logic [PERIOD_W-1:0]   period_reg;
    logic [TIME_W_DEF-1:0] ref_time;
    t_timer_result         due_count_q[$];
    int                    fails = 0;
    int                    checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // one timer item: result plus the reference update it causes
    function automatic t_timer_result count_elapsed_periods(
        input logic [KIND_W-1:0] kind,
        input logic [NOW_W-1:0]  now,
        input logic              regular
    );
        t_timer_result         res;
        logic [TIME_W_DEF-1:0] elapsed;
        logic [TIME_W_DEF-1:0] count;
        res     = '0;
        elapsed = now - ref_time;
        count   = elapsed / period_reg;
        case (kind)
            KIND_CHECK: begin
                res.due = (elapsed >= period_reg);
            end
            KIND_CYCLE: begin
                if (count != '0) begin
                    if (regular)
                        ref_time = ref_time + count * period_reg;  // wraps mod 2^32
                    else
                        ref_time = now;
                    res.due = 1'b1;
                end
                res.periods = count;
            end
            KIND_RESTART: begin
                ref_time = now;
            end
            default: ;  // unused kind: no state change, zero result
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_timer_result want;
        t_timer_result got;
        if (!i_rst_n) begin
            period_reg = 32'd1;
            ref_time   = '0;
            due_count_q.delete();
        end else begin
            if (i_cfg_we)
                period_reg = (i_cfg_wdata == '0) ? 32'd1 : i_cfg_wdata;
            if (i_in_valid && i_in_ready)
                due_count_q.push_back(count_elapsed_periods(i_in_kind, i_in_now, i_in_regular));
            if (i_out_valid && i_out_ready) begin
                got.due     = i_out_due;
                got.periods = i_out_periods;
                if (due_count_q.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("Result %0d with no item outstanding: due=%0b periods=%0d",
                                 checked, got.due, got.periods);
                    fails++;
                end else begin
                    want = due_count_q.pop_front();
                    if (want.due !== got.due || want.periods !== got.periods) begin
                        if (fails < MAX_REPORTS) begin
                            $display("Mismatch on result %0d: expected due=%0b periods=%0d,",
                                     checked, want.due, want.periods);
                            $display("    got due=%0b periods=%0d", got.due, got.periods);
                        end
                        fails++;
                    end
                end
                checked++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_count_q.size();
        o_checked    <= checked;
    end

endmodule

[sim/tb_periodic_timer_catch_up_unit.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, period writes, timer items and the final verdict
module tb_periodic_timer_catch_up_unit;
    import ptcu_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SEG_ITEMS    = 112;
    localparam int NUM_SEGMENTS = 8;
    localparam int DRAIN_CYCLES = 50;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_wdata;

    ptcu_in_if  in_bus ();
    ptcu_out_if out_bus ();

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;

    int idle_pct  = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int settings_cnt = 0;
    logic [PERIOD_W-1:0]   cur_period = 32'd1;
    logic [TIME_W_DEF-1:0] wall = '0;

    periodic_timer_catch_up_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    timer_result_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (in_bus.valid),
        .i_in_ready    (in_bus.ready),
        .i_in_kind     (in_bus.kind),
        .i_in_now      (in_bus.now),
        .i_in_regular  (in_bus.regular),
        .i_out_valid   (out_bus.valid),
        .i_out_ready   (out_bus.ready),
        .i_out_due     (out_bus.due),
        .i_out_periods (out_bus.periods),
        .o_fail_count  (fail_cnt),
        .o_pending     (pending_cnt),
        .o_checked     (checked_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : result_drain
        out_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge the item is taken
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [NOW_W-1:0] now,
                             input logic regular);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid   <= 1'b1;
        in_bus.kind    <= kind;
        in_bus.now     <= now;
        in_bus.regular <= regular;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // period is only written once every result is back
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_period = (value == '0) ? 32'd1 : value;
        settings_cnt++;
    endtask

    // mostly a forward-running time base with steps near the period, some noise
    task automatic run_segment(input int n_items);
        logic [63:0]         p64;
        logic [63:0]         step64;
        logic [KIND_W-1:0]   kind;
        logic [NOW_W-1:0]    now;
        int                  pick;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 10) begin
                kind = KIND_W'($urandom_range(0, 3));
                now  = $urandom;
            end else begin
                p64 = {32'd0, cur_period};
                case ($urandom_range(0, 7))
                    0:       step64 = '0;
                    1:       step64 = p64 - 1;
                    2:       step64 = p64;
                    3:       step64 = p64 + 1;
                    4:       step64 = {32'd0, $urandom};
                    5:       step64 = {32'd0, $urandom} % (8 * p64 + 1);
                    default: step64 = {32'd0, $urandom} % (2 * p64 + 1);
                endcase
                wall = wall + step64[TIME_W_DEF-1:0];
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    kind = KIND_CHECK;
                else if (pick < 80)
                    kind = KIND_CYCLE;
                else if (pick < 95)
                    kind = KIND_RESTART;
                else
                    kind = KIND_UNUSED;
                now = wall;
            end
            send_item(kind, now, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] pval;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_bus.valid   = 1'b0;
        in_bus.kind    = KIND_CHECK;
        in_bus.now     = '0;
        in_bus.regular = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset period of one, reference at zero
        send_item(KIND_CHECK,   32'h0000_0000, 1'b0);
        send_item(KIND_CHECK,   32'h0000_0001, 1'b0);
        send_item(KIND_CYCLE,   32'h0000_0005, 1'b1);
        send_item(KIND_CYCLE,   32'h0000_0005, 1'b1);
        send_item(KIND_CYCLE,   32'hFFFF_FFFF, 1'b0);
        send_item(KIND_UNUSED,  32'hFFFF_FFFF, 1'b1);
        send_item(KIND_CHECK,   32'h0000_0000, 1'b1);  // elapsed wraps through zero
        send_item(KIND_RESTART, 32'h7FFF_FFFF, 1'b0);

        // largest period: one count, regular advance wraps
        write_period(32'hFFFF_FFFF);
        send_item(KIND_CHECK,   32'h7FFF_FFFE, 1'b0);
        send_item(KIND_CYCLE,   32'h7FFF_FFFE, 1'b1);
        send_item(KIND_CHECK,   32'h7FFF_FFFD, 1'b0);

        // zero write must behave as period one
        write_period(32'h0000_0000);
        send_item(KIND_CYCLE,   32'h0000_0000, 1'b1);
        send_item(KIND_CYCLE,   32'hFFFF_FFFF, 1'b1);

        write_period(32'h8000_0001);
        send_item(KIND_RESTART, 32'h0000_0000, 1'b1);
        send_item(KIND_CYCLE,   32'hFFFF_FFFF, 1'b1);
        send_item(KIND_CYCLE,   32'h8000_0000, 1'b0);
        send_item(KIND_CHECK,   32'h0000_0000, 1'b1);

        // small period, huge count, sum wraps
        write_period(32'd3);
        send_item(KIND_RESTART, 32'hFFFF_FFFE, 1'b0);
        send_item(KIND_CYCLE,   32'h0000_0004, 1'b1);
        send_item(KIND_CYCLE,   32'h0000_0003, 1'b1);
        send_item(KIND_CHECK,   32'h0000_0002, 1'b0);

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0:       pval = 32'd1;
                1:       pval = $urandom_range(2, 16);
                2:       pval = 32'd0;
                3:       pval = $urandom_range(17, 5000);
                4:       pval = 32'hFFFF_FFFF;
                5:       pval = $urandom;
                6:       pval = 32'h8000_0000;
                default: pval = $urandom_range(1, 1 << 20);
            endcase
            write_period(pval);
            case (seg % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 86;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 86;
                end
                default: begin
                    idle_pct  = 38;
                    stall_pct = 38;
                end
            endcase
            run_segment(SEG_ITEMS);
        end

        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d timer items over %0d period writes and four handshake mixes",
                 items_sent, settings_cnt);
        $display("Compared %0d results, %0d failed", checked_cnt, fail_cnt);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
